// File: rtl/nrsss_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nrsss_pkg: shared types, constants and functions
// Fixed-point constants, the CORDIC arctangent table and the record types
// that travel along the rectangle pipeline.
// ---------------------------------------------------------------------------
package nrsss_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int DIM_BITS      = 13;
  localparam int DIV_BITS      = 35;
  localparam int XY_W          = 34;

  localparam logic signed [17:0] PI_Q13      = 18'sd25736;
  localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_ROT_EN  = 3'd0;
  localparam logic [2:0] REG_ROT_OFS = 3'd1;
  localparam logic [2:0] REG_SHIFT_X = 3'd2;
  localparam logic [2:0] REG_SHIFT_Y = 3'd3;
  localparam logic [2:0] REG_SCALE_X = 3'd4;
  localparam logic [2:0] REG_SCALE_Y = 3'd5;
  localparam logic [2:0] REG_SQUARE  = 3'd6;

  // Square modes.
  localparam logic [1:0] SQ_LONG  = 2'd1;
  localparam logic [1:0] SQ_SHORT = 2'd2;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [XY_W-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [DIM_BITS:0]   rem;
    logic [DIV_BITS-1:0] nq;
  } div_t;

  typedef struct packed {
    logic signed [19:0] cx;
    logic signed [19:0] cy;
    logic [18:0]        w;
    logic [18:0]        h;
    logic [DIM_BITS:0]  dw;
    logic [DIM_BITS:0]  dh;
    logic signed [23:0] tx;
    logic signed [23:0] ty;
    logic               azero;
    logic               neg;
    logic               sgnx;
    logic               sgny;
  } ctx_t;

  // arctan(2^-i) in Q0.30.
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048576;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // One correction step into [-pi, pi).
  function automatic logic signed [17:0] wrap_angle(input logic signed [17:0] a);
    logic signed [17:0] r;
    r = a;
    if (r < -PI_Q13) r = r + TWO_PI_Q13;
    if (r >= PI_Q13) r = r - TWO_PI_Q13;
    return r;
  endfunction

  // Image dimension: zero reads as one, large values clamp.
  function automatic logic [DIM_BITS:0] dim_clamp(input logic [13:0] v);
    logic [DIM_BITS:0] r;
    if (v == 14'd0) r = (DIM_BITS+1)'(1);
    else if (v > 14'(1 << DIM_BITS)) r = (DIM_BITS+1)'(1 << DIM_BITS);
    else r = (DIM_BITS+1)'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/normalized_rect_shift_square_scale.sv
`default_nettype none
// ---------------------------------------------------------------------------
// normalized_rect_shift_square_scale: rotated rectangle shift/square/scale
// Moves, optionally squares and scales one normalized rotated rectangle per
// transfer, with saturated fixed-point results.
// ---------------------------------------------------------------------------
// Usage:
// One rectangle enters per transfer on the s_axis channel and one result
// leaves per transfer on the m_axis channel, in order. The block takes a new
// rectangle in every cycle while the skid register is empty: the pipeline
// is a chain of 16 CORDIC cells and 35 restoring divider cells (four lanes
// wide), framed by a few multiply and add stages, so throughput is one
// rectangle per cycle while the skid register is empty. Each rectangle
// passes the CORDIC chain and then the divider chain, in that order.
// When the receiver stalls, the result sits in the output register and one
// more result can land in a skid register; once the skid register is full
// the whole pipeline and s_axis_tready hold until the output is taken.
// Reset empties the pipeline and loads the configuration registers with
// their defaults (unit scale factors, everything else zero). Configuration
// is written through cfg_we_i / cfg_idx_i / cfg_data_i while no rectangle
// is in flight.
// ---------------------------------------------------------------------------
module normalized_rect_shift_square_scale (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // center_x_in[19:0], center_y_in[39:20], size_w_in[58:40], size_h_in[77:59],
  // angle_in[93:78], img_w[107:94], img_h[121:108], zero fill above
  input  wire logic [127:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // center_x_out[19:0], center_y_out[39:20], size_w_out[58:40],
  // size_h_out[77:59], zero fill above
  output logic [79:0]      m_axis_tdata
);
  import nrsss_pkg::*;

  // Pipeline stage numbers index the context registers ctx_q and valid bits v_q.
  localparam int ST_CIN  = 1;
  localparam int ST_TRIG = 2 + CORDIC_STAGES;
  localparam int ST_MUL1 = ST_TRIG + 1;
  localparam int ST_MUL2 = ST_MUL1 + 1;
  localparam int ST_SUM  = ST_MUL2 + 1;
  localparam int ST_DIV  = ST_SUM + 1;
  localparam int ST_LAST = ST_DIV + DIV_BITS;
  localparam int NST     = ST_LAST + 1;

  // Configuration registers.
  logic               rot_en_q;
  logic signed [15:0] rot_ofs_q, sxf_q, syf_q;
  logic [15:0]        scx_q, scy_q;
  logic [1:0]         sq_q;
  logic               sq_on;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_en_q  <= 1'b0;
      rot_ofs_q <= '0;
      sxf_q     <= '0;
      syf_q     <= '0;
      scx_q     <= 16'd4096;
      scy_q     <= 16'd4096;
      sq_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROT_EN:  rot_en_q  <= cfg_data_i[0];
        REG_ROT_OFS: rot_ofs_q <= $signed(cfg_data_i);
        REG_SHIFT_X: sxf_q     <= $signed(cfg_data_i);
        REG_SHIFT_Y: syf_q     <= $signed(cfg_data_i);
        REG_SCALE_X: scx_q     <= cfg_data_i;
        REG_SCALE_Y: scy_q     <= cfg_data_i;
        REG_SQUARE:  sq_q      <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign sq_on = (sq_q == SQ_LONG) || (sq_q == SQ_SHORT);

  // The pipeline advances whenever the skid register is free.
  logic en, in_acc;
  logic skid_vld_q, out_vld_q;
  logic [NST-1:0] v_q;

  assign en            = !skid_vld_q;
  assign s_axis_tready = en;
  assign in_acc        = s_axis_tvalid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], in_acc};
    end
  end

  // Per-item context travels alongside the arithmetic.
  ctx_t ctx_q [NST];
  ctx_t ctx_d [NST];
  ctx_t ctx0_d;

  // Stage 0: unpack, clamp image size, first shift products, final angle.
  logic signed [19:0] in_cx, in_cy;
  logic [18:0]        in_w, in_h;
  logic signed [15:0] in_a;
  logic signed [35:0] txp, typ, txr, tyr;
  logic signed [17:0] a_sum, afin;
  logic signed [17:0] ang_q;

  always_comb begin
    in_cx = $signed(s_axis_tdata[19:0]);
    in_cy = $signed(s_axis_tdata[39:20]);
    in_w  = s_axis_tdata[58:40];
    in_h  = s_axis_tdata[77:59];
    in_a  = $signed(s_axis_tdata[93:78]);
    txp   = $signed({1'b0, in_w}) * sxf_q;
    typ   = $signed({1'b0, in_h}) * syf_q;
    txr   = txp + 36'sd2048;
    tyr   = typ + 36'sd2048;
    a_sum = 18'(in_a) + 18'(rot_ofs_q);
    afin  = rot_en_q ? wrap_angle(a_sum) : 18'(in_a);
    ctx0_d.cx    = in_cx;
    ctx0_d.cy    = in_cy;
    ctx0_d.w     = in_w;
    ctx0_d.h     = in_h;
    ctx0_d.dw    = dim_clamp(s_axis_tdata[107:94]);
    ctx0_d.dh    = dim_clamp(s_axis_tdata[121:108]);
    ctx0_d.tx    = txr[35:12];
    ctx0_d.ty    = tyr[35:12];
    ctx0_d.azero = (afin == 18'sd0);
    ctx0_d.neg   = 1'b0;
    ctx0_d.sgnx  = 1'b0;
    ctx0_d.sgny  = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (en) ang_q <= afin;
  end

  // Stage 1: fold the angle into [-pi/2, pi/2] and seed the CORDIC.
  logic signed [17:0] aw;
  logic               fold_neg;
  cordic_t            cin_d;
  cordic_t            cord [CORDIC_STAGES+1];

  always_comb begin
    aw       = wrap_angle(ang_q);
    fold_neg = 1'b0;
    if (aw > HALF_PI_Q13) begin
      aw       = aw - PI_Q13;
      fold_neg = 1'b1;
    end else if (aw < -HALF_PI_Q13) begin
      aw       = aw + PI_Q13;
      fold_neg = 1'b1;
    end
    cin_d.x = CORDIC_GAIN_Q30;
    cin_d.y = '0;
    cin_d.z = XY_W'(aw) <<< 17;
  end

  always_ff @(posedge clk_i) begin
    if (en) cord[0] <= cin_d;
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    nrsss_cordic_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .idx_i (5'(k)),
      .d_i   (cord[k]),
      .d_o   (cord[k+1])
    );
  end

  // Trig stage: round cosine and sine to Q16, undo the fold.
  logic signed [XY_W-1:0] xs, ys;
  logic signed [17:0]     c_q, s_q, c_d, s_d;

  always_comb begin
    xs  = cord[CORDIC_STAGES].x + 34'sd8192;
    ys  = cord[CORDIC_STAGES].y + 34'sd8192;
    c_d = ctx_q[ST_TRIG-1].neg ? -xs[31:14] : xs[31:14];
    s_d = ctx_q[ST_TRIG-1].neg ? -ys[31:14] : ys[31:14];
  end

  // First products: shift times cos/sin, and sides in pixels.
  logic signed [41:0] tc_q, ts_q, tyc_q, tys_q;
  logic [32:0]        lw_q, lh_q;
  // Second products: scale by image size; pick the square side.
  logic signed [56:0] pa_q, pb_q, pc_q, pd_q;
  logic [32:0]        side_q, side_d;
  // Sums and rounding bias for the divisions.
  logic signed [57:0] nx_q, ny_q;
  logic [33:0]        sdw_q, sdh_q;

  always_comb begin
    if (sq_q == SQ_LONG) side_d = (lw_q > lh_q) ? lw_q : lh_q;
    else                 side_d = (lw_q < lh_q) ? lw_q : lh_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q    <= c_d;
      s_q    <= s_d;
      tc_q   <= ctx_q[ST_TRIG].tx * c_q;
      ts_q   <= ctx_q[ST_TRIG].tx * s_q;
      tyc_q  <= ctx_q[ST_TRIG].ty * c_q;
      tys_q  <= ctx_q[ST_TRIG].ty * s_q;
      lw_q   <= ctx_q[ST_TRIG].w * ctx_q[ST_TRIG].dw;
      lh_q   <= ctx_q[ST_TRIG].h * ctx_q[ST_TRIG].dh;
      pa_q   <= tc_q  * $signed({1'b0, ctx_q[ST_MUL1].dw});
      pb_q   <= ts_q  * $signed({1'b0, ctx_q[ST_MUL1].dw});
      pc_q   <= tys_q * $signed({1'b0, ctx_q[ST_MUL1].dh});
      pd_q   <= tyc_q * $signed({1'b0, ctx_q[ST_MUL1].dh});
      side_q <= side_d;
      nx_q   <= 58'(pa_q) - 58'(pc_q);
      ny_q   <= 58'(pb_q) + 58'(pd_q);
      sdw_q  <= 34'(side_q) + 34'(ctx_q[ST_MUL2].dw >> 1);
      sdh_q  <= 34'(side_q) + 34'(ctx_q[ST_MUL2].dh >> 1);
    end
  end

  // Divider setup: magnitude plus half the divisor, dropped by 16 bits, and
  // clamped where the quotient is far beyond the saturation range anyway.
  logic [57:0]         mx, my;
  logic [58:0]         mx2, my2;
  div_t                dv [DIV_BITS+1][4];
  div_t                dv0_d [4];

  always_comb begin
    mx  = nx_q[57] ? 58'(-nx_q) : 58'(nx_q);
    my  = ny_q[57] ? 58'(-ny_q) : 58'(ny_q);
    mx2 = {1'b0, mx} + (59'(ctx_q[ST_SUM].dw) << 15);
    my2 = {1'b0, my} + (59'(ctx_q[ST_SUM].dh) << 15);
    for (int l = 0; l < 4; l++) dv0_d[l].rem = '0;
    dv0_d[0].nq = (|mx2[58:16+DIV_BITS]) ? '1 : mx2[16+DIV_BITS-1:16];
    dv0_d[1].nq = (|my2[58:16+DIV_BITS]) ? '1 : my2[16+DIV_BITS-1:16];
    dv0_d[2].nq = DIV_BITS'(sdw_q);
    dv0_d[3].nq = DIV_BITS'(sdh_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 4; l++) dv[0][l] <= dv0_d[l];
    end
  end

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    for (genvar l = 0; l < 4; l++) begin : g_lane
      nrsss_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .dvs_i ((l % 2 == 0) ? ctx_q[ST_DIV+k].dw : ctx_q[ST_DIV+k].dh),
        .d_i   (dv[k][l]),
        .d_o   (dv[k+1][l])
      );
    end
  end

  // Context shift with the few fields that are filled in on the way.
  always_comb begin
    ctx_d[0] = ctx0_d;
    for (int k = 1; k < NST; k++) ctx_d[k] = ctx_q[k-1];
    ctx_d[ST_CIN].neg  = fold_neg;
    ctx_d[ST_DIV].sgnx = nx_q[57];
    ctx_d[ST_DIV].sgny = ny_q[57];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NST; k++) ctx_q[k] <= ctx_d[k];
    end
  end

  // Final stage: apply the quotient, scale the sides, saturate.
  ctx_t               fc;
  logic [DIV_BITS-1:0] qx, qy, nw, nh;
  logic signed [36:0] qxs, qys;
  logic signed [37:0] cxs, cys;
  logic [50:0]        pw, ph;
  logic [38:0]        sw, sh;
  logic signed [19:0] cx_o, cy_o;
  logic [18:0]        w_o, h_o;
  logic [77:0]        res;

  always_comb begin
    fc  = ctx_q[ST_LAST];
    qx  = dv[DIV_BITS][0].nq;
    qy  = dv[DIV_BITS][1].nq;
    qxs = fc.sgnx ? -$signed({2'b0, qx}) : $signed({2'b0, qx});
    qys = fc.sgny ? -$signed({2'b0, qy}) : $signed({2'b0, qy});
    cxs = 38'(fc.cx) + (fc.azero ? 38'(fc.tx) : 38'(qxs));
    cys = 38'(fc.cy) + (fc.azero ? 38'(fc.ty) : 38'(qys));
    if (cxs < -38'sd524288)     cx_o = 20'sh80000;
    else if (cxs > 38'sd524287) cx_o = 20'sh7FFFF;
    else                        cx_o = cxs[19:0];
    if (cys < -38'sd524288)     cy_o = 20'sh80000;
    else if (cys > 38'sd524287) cy_o = 20'sh7FFFF;
    else                        cy_o = cys[19:0];
    nw  = sq_on ? dv[DIV_BITS][2].nq : DIV_BITS'(fc.w);
    nh  = sq_on ? dv[DIV_BITS][3].nq : DIV_BITS'(fc.h);
    pw  = nw * scx_q + 51'd2048;
    ph  = nh * scy_q + 51'd2048;
    sw  = pw[50:12];
    sh  = ph[50:12];
    w_o = (sw > 39'd524287) ? 19'h7FFFF : sw[18:0];
    h_o = (sh > 39'd524287) ? 19'h7FFFF : sh[18:0];
    res = {h_o, w_o, cy_o, cx_o};
  end

  // Output register and skid register.
  logic        take;
  logic [77:0] out_q, skid_q;

  assign take = out_vld_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (en) begin
      if (!out_vld_q || take) out_vld_q <= v_q[ST_LAST];
      else if (v_q[ST_LAST])  skid_vld_q <= 1'b1;
    end else if (take) begin
      skid_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (!out_vld_q || take) out_q <= res;
      else                    skid_q <= res;
    end else if (take) begin
      out_q <= skid_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b0, out_q};

  // A full skid register always sits behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q) else $error("skid full with empty output");

  // While the skid register is full, the pipeline does not move.
  a_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> (v_q == $past(v_q))) else $error("pipeline moved while stalled");

  // A finished item meeting a stalled output must land in the skid register.
  a_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && v_q[ST_LAST] && out_vld_q && !m_axis_tready) |=> skid_vld_q)
    else $error("finished item dropped");

endmodule
`default_nettype wire

// File: rtl/nrsss_cordic_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nrsss_cordic_cell: one rotation-mode CORDIC iteration
// Rotates by +/- arctan(2^-i) and registers the result for the next cell.
// ---------------------------------------------------------------------------
module nrsss_cordic_cell (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [4:0]        idx_i,
  input  wire nrsss_pkg::cordic_t d_i,
  output nrsss_pkg::cordic_t     d_o
);
  import nrsss_pkg::*;

  logic signed [XY_W-1:0] dx, dy, at;
  cordic_t d_d, d_q;

  always_comb begin
    dx = d_i.y >>> idx_i;
    dy = d_i.x >>> idx_i;
    at = $signed({4'b0, atan_q30(idx_i)});
    if (!d_i.z[XY_W-1]) begin
      d_d.x = d_i.x - dx;
      d_d.y = d_i.y + dy;
      d_d.z = d_i.z - at;
    end else begin
      d_d.x = d_i.x + dx;
      d_d.y = d_i.y - dy;
      d_d.z = d_i.z + at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) d_q <= d_d;
  end

  assign d_o = d_q;
endmodule
`default_nettype wire

// File: rtl/nrsss_div_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nrsss_div_cell: one restoring division step
// Brings in the next dividend bit, trial-subtracts the divisor and shifts
// the quotient bit into the low end of the shared dividend/quotient word.
// ---------------------------------------------------------------------------
module nrsss_div_cell (
  input  wire logic                             clk_i,
  input  wire logic                             en_i,
  input  wire logic [nrsss_pkg::DIM_BITS:0]     dvs_i,
  input  wire nrsss_pkg::div_t                  d_i,
  output nrsss_pkg::div_t                       d_o
);
  import nrsss_pkg::*;

  logic [DIM_BITS+1:0] t, diff;
  logic                ge;
  div_t                d_d, d_q;

  always_comb begin
    t    = {d_i.rem, d_i.nq[DIV_BITS-1]};
    diff = t - {1'b0, dvs_i};
    ge   = (t >= {1'b0, dvs_i});
    d_d.rem = ge ? diff[DIM_BITS:0] : t[DIM_BITS:0];
    d_d.nq  = {d_i.nq[DIV_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) d_q <= d_d;
  end

  assign d_o = d_q;
endmodule
`default_nettype wire

// File: dv/normalized_rect_shift_square_scale_tb.sv
// ---------------------------------------------------------------------------
// normalized_rect_shift_square_scale_tb: self-checking rectangle testbench
// Drives rotated rectangles through the stream port under several register
// settings, predicts each shifted, squared and scaled result with its own
// fixed-point model and compares every field in order.
// ---------------------------------------------------------------------------
module normalized_rect_shift_square_scale_tb;
  import nrsss_pkg::*;

  localparam int LATENCY    = 58;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [18:0] h;
    logic [18:0] w;
    logic [19:0] cy;
    logic [19:0] cx;
  } rect_out_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = REG_ROT_EN;
  logic [15:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // center_x_in, center_y_in, size_w_in, size_h_in, angle_in, img_w, img_h
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // center_x_out, center_y_out, size_w_out, size_h_out
  logic [79:0]  m_axis_tdata;

  normalized_rect_shift_square_scale dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the configuration registers.
  logic               rot_en_q;
  longint             rot_ofs_q, shift_x_q, shift_y_q, scale_x_q, scale_y_q;
  logic [1:0]         square_q;

  rect_out_t expected_rects[$];
  int  mismatch_cnt = 0;
  bit  sink_stalls = 1'b1;
  bit  src_gaps = 1'b1;
  int  idle_cycles = 0;

  // Arithmetic shift right that rounds toward minus infinity.
  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  // Division rounding to nearest, ties away from zero.
  function automatic longint round_div(longint n, longint d);
    longint m, q;
    m = (n < 0) ? -n : n;
    q = (m + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic longint clamp_dim(logic [13:0] v);
    if (v == 0) return 1;
    if (v > (1 << DIM_BITS)) return 1 << DIM_BITS;
    return v;
  endfunction

  function automatic longint wrap_q13(longint a);
    if (a < -25736) a += 51472;
    if (a >= 25736) a -= 51472;
    return a;
  endfunction

  // Rotation-mode CORDIC on a Q3.13 angle; cos and sin come back in Q16.
  task automatic cordic_q16(input longint ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    bit     flip;
    flip = 1'b0;
    x = 652032874;
    y = 0;
    ang = wrap_q13(ang);
    if (ang > 12868) begin
      ang -= 25736; flip = 1'b1;
    end else if (ang < -12868) begin
      ang += 25736; flip = 1'b1;
    end
    z = ang * 131072;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_q30(5'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(atan_q30(5'(i)));
      end
    end
    x = asr(x + (1 << 13), 14);
    y = asr(y + (1 << 13), 14);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic [19:0] sat_center(longint v);
    if (v < -524288) v = -524288;
    if (v > 524287) v = 524287;
    return v[19:0];
  endfunction

  function automatic logic [18:0] sat_size(longint v);
    return (v > 524287) ? 19'h7FFFF : v[18:0];
  endfunction

  task automatic predict_rect(input logic [127:0] d, output rect_out_t r);
    longint cx, cy, w, h, ang, iw, ih, tx, ty, nw, nh, c, s, px, py, lw, lh, side;
    cx = longint'($signed(d[19:0]));
    cy = longint'($signed(d[39:20]));
    w = d[58:40];
    h = d[77:59];
    ang = longint'($signed(d[93:78]));
    iw = clamp_dim(d[107:94]);
    ih = clamp_dim(d[121:108]);
    tx = asr(w * shift_x_q + 2048, 12);
    ty = asr(h * shift_y_q + 2048, 12);
    nw = w;
    nh = h;
    if (rot_en_q) ang = wrap_q13(ang + rot_ofs_q);
    if (ang == 0) begin
      cx += tx;
      cy += ty;
    end else begin
      cordic_q16(ang, c, s);
      px = tx * iw;
      py = ty * ih;
      cx += round_div(px * c - py * s, iw << 16);
      cy += round_div(px * s + py * c, ih << 16);
    end
    if (square_q == SQ_LONG || square_q == SQ_SHORT) begin
      lw = w * iw;
      lh = h * ih;
      if (square_q == SQ_LONG) side = (lw > lh) ? lw : lh;
      else side = (lw < lh) ? lw : lh;
      nw = round_div(side, iw);
      nh = round_div(side, ih);
    end
    r.cx = sat_center(cx);
    r.cy = sat_center(cy);
    r.w = sat_size((nw * scale_x_q + 2048) >>> 12);
    r.h = sat_size((nh * scale_y_q + 2048) >>> 12);
  endtask

  // Register writes only happen with the pipeline drained.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_ROT_EN:  rot_en_q = val[0];
      REG_ROT_OFS: rot_ofs_q = longint'($signed(val));
      REG_SHIFT_X: shift_x_q = longint'($signed(val));
      REG_SHIFT_Y: shift_y_q = longint'($signed(val));
      REG_SCALE_X: scale_x_q = val;
      REG_SCALE_Y: scale_y_q = val;
      REG_SQUARE:  square_q = val[1:0];
      default: ;
    endcase
  endtask

  task automatic drain_pipe();
    while (expected_rects.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic program_regs(input logic re, input logic [15:0] ro, input logic [15:0] sx,
                              input logic [15:0] sy, input logic [15:0] kx,
                              input logic [15:0] ky, input logic [1:0] sq);
    drain_pipe();
    write_reg(REG_ROT_EN, {15'd0, re});
    write_reg(REG_ROT_OFS, ro);
    write_reg(REG_SHIFT_X, sx);
    write_reg(REG_SHIFT_Y, sy);
    write_reg(REG_SCALE_X, kx);
    write_reg(REG_SCALE_Y, ky);
    write_reg(REG_SQUARE, {14'd0, sq});
  endtask

  // Sends one rectangle; the expectation is queued when the transfer happens.
  task automatic send_rect(input logic [19:0] cx, input logic [19:0] cy,
                           input logic [18:0] w, input logic [18:0] h,
                           input logic [15:0] ang, input logic [13:0] iw,
                           input logic [13:0] ih);
    rect_out_t r;
    logic [127:0] d;
    if (src_gaps && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 10)) @(negedge clk_i);
    d = {6'd0, ih, iw, ang, h, w, cy, cx};
    predict_rect(d, r);
    s_axis_tdata = d;
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_rects.push_back(r);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // Random dimension: mostly legal sizes, sometimes zero or above the clamp.
  function automatic logic [13:0] rand_dim();
    case ($urandom_range(0, 7))
      0: return 14'd0;
      1: return 14'($urandom_range(8193, 16383));
      2: return 14'd8192;
      default: return 14'($urandom_range(1, 4096));
    endcase
  endfunction

  task automatic send_random(int n);
    for (int i = 0; i < n; i++)
      send_rect(20'($urandom), 20'($urandom), 19'($urandom_range(0, 131071)) |
                (($urandom_range(0, 9) == 0) ? 19'($urandom) : 19'd0),
                19'($urandom_range(0, 131071)), 16'($urandom), rand_dim(), rand_dim());
  endtask

  task automatic test_directed();
    // Field extremes, zero angle, angle wrap, zero and oversized dimensions.
    send_rect(20'h00000, 20'h00000, 19'd0, 19'd0, 16'd0, 14'd1, 14'd1);
    send_rect(20'h7FFFF, 20'h80000, 19'h7FFFF, 19'h7FFFF, 16'h7FFF, 14'h3FFF, 14'd0);
    send_rect(20'h80000, 20'h7FFFF, 19'h7FFFF, 19'd1, 16'h8000, 14'd0, 14'h3FFF);
    send_rect(20'h10000, 20'h08000, 19'h10000, 19'h08000, 16'd12868, 14'd640, 14'd480);
    send_rect(20'hF0000, 20'h20000, 19'h04000, 19'h20000, -16'sd12868, 14'd8192, 14'd8193);
    send_rect(20'h00100, 20'h00200, 19'h08000, 19'h10000, 16'd25736, 14'd1920, 14'd1080);
    send_rect(20'h00100, 20'h00200, 19'h08000, 19'h10000, -16'sd25736, 14'd100, 14'd3000);
    send_rect(20'h00100, 20'h00200, 19'h08000, 19'h10000, 16'd1, 14'd7, 14'd13);
    send_rect(20'h00100, 20'h00200, 19'h08000, 19'h10000, 16'hFFFF, 14'd13, 14'd7);
  endtask

  task automatic test_shift_rotate();
    program_regs(1'b1, 16'd8000, 16'h1000, 16'hF800, 16'h1000, 16'h1000, 2'd0);
    test_directed();
    send_random(60);
    program_regs(1'b1, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd0, 2'd3);
    test_directed();
    send_random(50);
  endtask

  task automatic test_square();
    program_regs(1'b0, 16'h8000, 16'h0400, 16'h0400, 16'h1800, 16'h0800, SQ_LONG);
    send_random(80);
    program_regs(1'b1, 16'h8000, 16'h8000, 16'h7FFF, 16'd0, 16'hFFFF, SQ_SHORT);
    send_random(80);
  endtask

  task automatic test_quiet_end();
    // Pipeline runs empty once more, then full speed with no stalls.
    drain_pipe();
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    program_regs(1'b0, 16'd0, 16'hFC00, 16'h0200, 16'h1000, 16'h1000, 2'd0);
    send_random(120);
  endtask

  // Result sink with random stall bursts.
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(negedge clk_i);
      if (burst > 0) burst--;
      else if (sink_stalls && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 10);
      m_axis_tready = (burst == 0);
    end
  end

  // Result checker and the watchdog that counts cycles without a transfer.
  always @(posedge clk_i) begin
    rect_out_t got, exp_r;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[77:0];
        if (expected_rects.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected result %h", got);
        end else begin
          exp_r = expected_rects.pop_front();
          if (got.cx !== exp_r.cx || got.cy !== exp_r.cy || got.w !== exp_r.w ||
              got.h !== exp_r.h) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch exp cx=%h cy=%h w=%h h=%h got cx=%h cy=%h w=%h h=%h",
                       exp_r.cx, exp_r.cy, exp_r.w, exp_r.h, got.cx, got.cy, got.w, got.h);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles > STALL_LIMIT) begin
      $display("FAIL normalized_rect_shift_square_scale");
      $finish;
    end
  end

  initial begin
    rot_en_q = 1'b0; rot_ofs_q = 0; shift_x_q = 0; shift_y_q = 0;
    scale_x_q = 4096; scale_y_q = 4096; square_q = 2'd0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    // Reset values first: unit scale, no shift, no rotation offset.
    test_directed();
    test_shift_rotate();
    test_square();
    test_quiet_end();
    drain_pipe();
    if (mismatch_cnt == 0 && expected_rects.size() == 0)
      $display("PASS normalized_rect_shift_square_scale");
    else
      $display("FAIL normalized_rect_shift_square_scale");
    $finish;
  end

endmodule

// File: files.f
rtl/nrsss_pkg.sv
rtl/nrsss_cordic_cell.sv
rtl/nrsss_div_cell.sv
rtl/normalized_rect_shift_square_scale.sv
dv/normalized_rect_shift_square_scale_tb.sv
